@@ rtl/divisor_count_sum_product_mod_core_assert.svh @@
// Assertion macros for the checker file of this core.
`ifndef DIVISOR_COUNT_SUM_PRODUCT_MOD_CORE_ASSERT_SVH
`define DIVISOR_COUNT_SUM_PRODUCT_MOD_CORE_ASSERT_SVH

// Implication checked at every rising clock edge, ignored while reset is held.
`define DCSP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on the core clock and reset names.
`define DCSP_ASSERT(lbl, prop, msg) \
    `DCSP_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

@@ rtl/dcsp_pkg.sv @@
package dcsp_pkg;

    localparam int unsigned W     = 30;
    localparam int unsigned EXP_W = 60;

    // Moduli and their Barrett factors floor(2^60 / modulus).
    localparam logic [W-1:0] MOD_P       = 30'd1000000007;
    localparam logic [W-1:0] MOD_PHI     = 30'd1000000006;
    localparam logic [W-1:0] MOD_P_M2    = 30'd1000000005;
    localparam logic [W-1:0] MOD_P_M1    = 30'd1000000006;
    localparam logic [30:0]  BARRETT_P   = 31'd1152921496;
    localparam logic [30:0]  BARRETT_PHI = 31'd1152921497;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_COUNT,
        OP_MUL_RES,
        OP_MUL_SQR,
        OP_MUL_SFAC,
        OP_MUL_SUM,
        OP_MUL_PROD,
        OP_MUL_PHI,
        OP_POW_PA1,
        OP_POW_DINV,
        OP_POW_TERM,
        OP_POW_CPHI,
        OP_POW_PROD,
        OP_FINISH
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
        logic d_zero;
        logic last;
        logic out_busy;
    } t_stat;

endpackage

@@ rtl/dcsp_if.sv @@
// Input word channel: one (prime, exponent) pair.
interface dcsp_in_if;
    logic        valid;
    logic        ready;
    logic [29:0] prime;
    logic [29:0] prime_exponent;
    logic        last;

    modport source (output valid, prime, prime_exponent, last, input ready);
    modport sink (input valid, prime, prime_exponent, last, output ready);
endinterface

// Result word channel: count, sum and product of divisors.
interface dcsp_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] divisor_count;
    logic [29:0] divisor_sum;
    logic [29:0] divisor_product;

    modport source (output valid, divisor_count, divisor_sum, divisor_product, input ready);
    modport sink (input valid, divisor_count, divisor_sum, divisor_product, output ready);
endinterface

@@ rtl/dcsp_modmul.sv @@
// Five stage modular multiplier with Barrett reduction, one operation in flight.
module dcsp_modmul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_phi,
    input  logic [29:0] i_a,
    input  logic [29:0] i_b,
    output logic        o_done,
    output logic [29:0] o_y
);

    logic [4:0]  r_v;
    logic        r_phi;
    logic [59:0] r_x;
    logic [61:0] r_t;
    logic [31:0] r_qp;
    logic [31:0] r_r;
    logic [29:0] r_y;

    logic [59:0] w_prod;
    logic [30:0] w_m;
    logic [31:0] w_mod;
    logic [31:0] w_qp;
    logic [31:0] w_mod2;

    assign w_prod = i_a * i_b;
    assign w_m    = r_phi ? dcsp_pkg::BARRETT_PHI : dcsp_pkg::BARRETT_P;
    assign w_mod  = {2'b00, (r_phi ? dcsp_pkg::MOD_PHI : dcsp_pkg::MOD_P)};
    assign w_mod2 = {w_mod[30:0], 1'b0};
    // Only the low word of q*m is needed, the remainder is below 3m.
    assign w_qp   = r_t[61:31] * w_mod;

    // Stage valid shift register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_start};
        end
    end

    // Product, quotient estimate, remainder and final correction.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= w_prod;
            r_phi <= i_phi;
        end
        if (r_v[0]) begin
            r_t <= r_x[59:29] * w_m;
        end
        if (r_v[1]) begin
            r_qp <= w_qp;
        end
        if (r_v[2]) begin
            r_r <= r_x[31:0] - r_qp;
        end
        if (r_v[3]) begin
            if (r_r >= w_mod2) begin
                r_y <= 30'(r_r - w_mod2);
            end else if (r_r >= w_mod) begin
                r_y <= 30'(r_r - w_mod);
            end else begin
                r_y <= r_r[29:0];
            end
        end
    end

    assign o_done = r_v[4];
    assign o_y    = r_y;

endmodule

@@ rtl/dcsp_datapath.sv @@
// Accumulators, exponentiation registers, shared multiplier and result register.
module dcsp_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dcsp_pkg::t_cmd  i_cmd,
    output dcsp_pkg::t_stat o_stat,
    input  logic [29:0]     i_prime,
    input  logic [29:0]     i_prime_exponent,
    input  logic            i_last,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [29:0]     o_divisor_count,
    output logic [29:0]     o_divisor_sum,
    output logic [29:0]     o_divisor_product
);

    // Per item values.
    logic [29:0] r_pm, r_d, r_a1m, r_a1phi;
    logic [30:0] r_a1;
    logic [59:0] r_tri;
    logic        r_last;

    // Running residues.
    logic [29:0] r_count, r_sum, r_prod, r_cphi;

    // Exponentiation and temporaries.
    logic [29:0] r_res, r_base, r_num, r_t2;
    logic [59:0] r_exp;
    dcsp_pkg::t_op r_pend;

    // Result register.
    logic        r_out_valid;
    logic [29:0] r_oc, r_os, r_op;

    logic [30:0] w_a1;
    logic [60:0] w_tri;
    logic [29:0] w_pm;
    logic        w_start;
    logic        w_phi;
    logic [29:0] w_ma, w_mb;
    logic        w_done;
    logic [29:0] w_y;
    logic [29:0] w_res_m1;

    assign w_a1     = {1'b0, i_prime_exponent} + 31'd1;
    assign w_tri    = i_prime_exponent * w_a1;
    assign w_pm     = (i_prime >= dcsp_pkg::MOD_P) ? 30'(i_prime - dcsp_pkg::MOD_P) : i_prime;
    assign w_res_m1 = (r_res == '0) ? dcsp_pkg::MOD_P_M1 : 30'(r_res - 30'd1);

    // Multiplier operand selection.
    always_comb begin
        w_start = 1'b1;
        w_phi   = 1'b0;
        w_ma    = r_res;
        w_mb    = r_base;
        case (i_cmd.op)
            dcsp_pkg::OP_MUL_COUNT: begin
                w_ma = r_count;
                w_mb = r_a1m;
            end
            dcsp_pkg::OP_MUL_RES: begin
                w_ma = r_res;
                w_mb = r_base;
            end
            dcsp_pkg::OP_MUL_SQR: begin
                w_ma = r_base;
                w_mb = r_base;
            end
            dcsp_pkg::OP_MUL_SFAC: begin
                w_ma = r_num;
                w_mb = r_res;
            end
            dcsp_pkg::OP_MUL_SUM: begin
                w_ma = r_sum;
                w_mb = (r_d == '0) ? r_a1m : r_num;
            end
            dcsp_pkg::OP_MUL_PROD: begin
                w_ma = r_res;
                w_mb = r_t2;
            end
            dcsp_pkg::OP_MUL_PHI: begin
                w_ma  = r_cphi;
                w_mb  = r_a1phi;
                w_phi = 1'b1;
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    dcsp_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_phi   (w_phi),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_done),
        .o_y     (w_y)
    );

    // Item capture with the reduced forms of p and a+1.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pm   <= w_pm;
            r_d    <= (w_pm == '0) ? dcsp_pkg::MOD_P_M1 : 30'(w_pm - 30'd1);
            r_a1   <= w_a1;
            r_a1m  <= (w_a1 >= {1'b0, dcsp_pkg::MOD_P}) ?
                      30'(w_a1 - {1'b0, dcsp_pkg::MOD_P}) : w_a1[29:0];
            r_a1phi <= (w_a1 >= {1'b0, dcsp_pkg::MOD_PHI}) ?
                      30'(w_a1 - {1'b0, dcsp_pkg::MOD_PHI}) : w_a1[29:0];
            r_tri  <= w_tri[60:1];
            r_last <= i_last;
        end
    end

    // Exponentiation setup, temporaries and multiplier write back.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_pend <= i_cmd.op;
        end
        case (i_cmd.op)
            dcsp_pkg::OP_POW_PA1: begin
                r_base <= r_pm;
                r_exp  <= {29'd0, r_a1};
                r_res  <= 30'd1;
            end
            dcsp_pkg::OP_POW_DINV: begin
                r_num  <= w_res_m1;
                r_base <= r_d;
                r_exp  <= {30'd0, dcsp_pkg::MOD_P_M2};
                r_res  <= 30'd1;
            end
            dcsp_pkg::OP_POW_TERM: begin
                r_base <= r_pm;
                r_exp  <= r_tri;
                r_res  <= 30'd1;
            end
            dcsp_pkg::OP_POW_CPHI: begin
                r_base <= r_res;
                r_exp  <= {30'd0, r_cphi};
                r_res  <= 30'd1;
            end
            dcsp_pkg::OP_POW_PROD: begin
                r_t2   <= r_res;
                r_base <= r_prod;
                r_exp  <= {29'd0, r_a1};
                r_res  <= 30'd1;
            end
            default: begin
            end
        endcase
        if (w_done) begin
            case (r_pend)
                dcsp_pkg::OP_MUL_RES: begin
                    r_res <= w_y;
                end
                dcsp_pkg::OP_MUL_SQR: begin
                    r_base <= w_y;
                    r_exp  <= {1'b0, r_exp[59:1]};
                end
                dcsp_pkg::OP_MUL_SFAC: begin
                    r_num <= w_y;
                end
                default: begin
                end
            endcase
        end
    end

    // Running residues, back to one at reset and after a final pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == dcsp_pkg::OP_FINISH) begin
            r_count <= 30'd1;
            r_sum   <= 30'd1;
            r_prod  <= 30'd1;
            r_cphi  <= 30'd1;
        end else if (w_done) begin
            case (r_pend)
                dcsp_pkg::OP_MUL_COUNT: r_count <= w_y;
                dcsp_pkg::OP_MUL_SUM:   r_sum   <= w_y;
                dcsp_pkg::OP_MUL_PROD:  r_prod  <= w_y;
                dcsp_pkg::OP_MUL_PHI:   r_cphi  <= w_y;
                default: begin
                end
            endcase
        end
    end

    // Result register toward the output channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == dcsp_pkg::OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == dcsp_pkg::OP_FINISH) begin
            r_oc <= r_count;
            r_os <= r_sum;
            r_op <= r_prod;
        end
    end

    assign o_stat.mul_done = w_done;
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_lsb  = r_exp[0];
    assign o_stat.d_zero   = (r_d == '0);
    assign o_stat.last     = r_last;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_divisor_count   = r_oc;
    assign o_divisor_sum     = r_os;
    assign o_divisor_product = r_op;

endmodule

@@ rtl/dcsp_ctrl.sv @@
// Sequencer: steps the datapath through the per pair updates.
module dcsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dcsp_pkg::t_stat i_stat,
    output dcsp_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CNT, S_SUM0, S_SUM1, S_SUM2, S_SUMM, S_PR0, S_PR1,
        S_PR2, S_PR3, S_PHI, S_END, S_POW, S_SQR, S_WAIT
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_state r_pret, n_pret;

    // Next state and command decode.
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_pret    = r_pret;
        o_cmd.load = 1'b0;
        o_cmd.op  = dcsp_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CNT;
                end
            end
            S_CNT: begin
                o_cmd.op = dcsp_pkg::OP_MUL_COUNT;
                n_ret    = S_SUM0;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.mul_done) begin
                    n_state = r_ret;
                end
            end
            S_SUM0: begin
                if (i_stat.d_zero) begin
                    n_state = S_SUMM;
                end else begin
                    o_cmd.op = dcsp_pkg::OP_POW_PA1;
                    n_pret   = S_SUM1;
                    n_state  = S_POW;
                end
            end
            S_POW: begin
                if (i_stat.exp_zero) begin
                    n_state = r_pret;
                end else if (i_stat.exp_lsb) begin
                    o_cmd.op = dcsp_pkg::OP_MUL_RES;
                    n_ret    = S_SQR;
                    n_state  = S_WAIT;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.op = dcsp_pkg::OP_MUL_SQR;
                n_ret    = S_POW;
                n_state  = S_WAIT;
            end
            S_SUM1: begin
                o_cmd.op = dcsp_pkg::OP_POW_DINV;
                n_pret   = S_SUM2;
                n_state  = S_POW;
            end
            S_SUM2: begin
                o_cmd.op = dcsp_pkg::OP_MUL_SFAC;
                n_ret    = S_SUMM;
                n_state  = S_WAIT;
            end
            S_SUMM: begin
                o_cmd.op = dcsp_pkg::OP_MUL_SUM;
                n_ret    = S_PR0;
                n_state  = S_WAIT;
            end
            S_PR0: begin
                o_cmd.op = dcsp_pkg::OP_POW_TERM;
                n_pret   = S_PR1;
                n_state  = S_POW;
            end
            S_PR1: begin
                o_cmd.op = dcsp_pkg::OP_POW_CPHI;
                n_pret   = S_PR2;
                n_state  = S_POW;
            end
            S_PR2: begin
                o_cmd.op = dcsp_pkg::OP_POW_PROD;
                n_pret   = S_PR3;
                n_state  = S_POW;
            end
            S_PR3: begin
                o_cmd.op = dcsp_pkg::OP_MUL_PROD;
                n_ret    = S_PHI;
                n_state  = S_WAIT;
            end
            S_PHI: begin
                o_cmd.op = dcsp_pkg::OP_MUL_PHI;
                n_ret    = S_END;
                n_state  = S_WAIT;
            end
            S_END: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (!i_stat.out_busy) begin
                    o_cmd.op = dcsp_pkg::OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and return registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_pret  <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pret  <= n_pret;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/divisor_count_sum_product_mod_core.sv @@
// Channel  | Dir | Word
// ---------+-----+---------------------------------------------------------
// i_in     | in  | prime[29:0], prime_exponent[29:0], last
// o_out    | out | divisor_count[29:0], divisor_sum[29:0], divisor_product[29:0]
//
// One pair at a time. Each modular multiplication runs on the shared five stage
// multiplier. An exponentiation squares once on every exponent bit and multiplies
// once more on every set bit, over five exponentiations (a+1, 1e9+5, a(a+1)/2,
// running count, a+1) of up to 181 bits in all.
// Reset is synchronous, active low, and returns all residues to one.
// A stalled result word holds; a final pair waits only if one is still held.
module divisor_count_sum_product_mod_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcsp_in_if.sink    i_in,
    dcsp_out_if.source o_out
);

    dcsp_pkg::t_cmd  w_cmd;
    dcsp_pkg::t_stat w_stat;

    dcsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    dcsp_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_prime           (i_in.prime),
        .i_prime_exponent  (i_in.prime_exponent),
        .i_last            (i_in.last),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_divisor_count   (o_out.divisor_count),
        .o_divisor_sum     (o_out.divisor_sum),
        .o_divisor_product (o_out.divisor_product)
    );

endmodule

@@ rtl/dcsp_checker.sv @@
`include "divisor_count_sum_product_mod_core_assert.svh"

// Port level checks on the core.
module dcsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [89:0] i_out_word
);

    // A held result word stays until it is taken.
    `DCSP_ASSERT(a_out_hold,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word),
        "result word dropped or changed while stalled")

    // The core works on one pair at a time.
    `DCSP_ASSERT(a_busy_after_accept,
        i_in_valid && i_in_ready |=> !i_in_ready,
        "second pair taken while busy")

    // No result can appear right after a pair is taken.
    `DCSP_ASSERT(a_no_early_result,
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready),
        "result raised one cycle after a pair")

endmodule

bind divisor_count_sum_product_mod_core dcsp_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  ({o_out.divisor_count, o_out.divisor_sum, o_out.divisor_product})
);

@@ dv/tb_divisor_count_sum_product_mod_core.sv @@
`timescale 1ns / 100ps

module tb_divisor_count_sum_product_mod_core;

    localparam longint unsigned PRIME_MOD = 64'(dcsp_pkg::MOD_P);
    localparam longint unsigned PHI_MOD   = 64'(dcsp_pkg::MOD_PHI);
    localparam int              STALL_LIMIT = 20000;
    localparam int              DRAIN_CYCLES = 1500;
    localparam int              ITEM_TARGET = 1500;

    typedef struct {
        bit [29:0] prime;
        bit [29:0] expo;
        bit        last;
    } t_pair;

    typedef struct {
        bit [29:0] count;
        bit [29:0] sum;
        bit [29:0] product;
    } t_divisor_res;

    logic i_clk;
    logic i_rst_n;

    dcsp_in_if  in_ch ();
    dcsp_out_if out_ch ();

    divisor_count_sum_product_mod_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_pair            pair_q[$];
    t_divisor_res     divisor_q[$];
    t_pair            next_pair;
    longint unsigned  count_run, sum_run, product_run, count_phi_run;
    int               errors;
    int               pairs_sent;
    int               pairs_taken;
    int               results_seen;
    int               idle_cycles;
    int               hold_left;
    bit               hold_done;
    bit               in_taken;

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Modular product below the prime modulus.
    function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y);
        return (x * y) % PRIME_MOD;
    endfunction

    // Square-and-multiply power with a 64-bit exponent.
    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e);
        longint unsigned r;
        r = 1;
        b = b % PRIME_MOD;
        while (e != 0) begin
            if (e[0]) r = mul_mod(r, b);
            b = mul_mod(b, b);
            e = e >> 1;
        end
        return r;
    endfunction

    // Fold one accepted pair into the running residues; a last pair yields a result.
    function automatic void fold_divisor_pair(bit [29:0] p, bit [29:0] a, bit l);
        longint unsigned pm, ae, a1, a1m, a1phi, d, sfac, term;
        t_divisor_res r;
        pm    = 64'(p) % PRIME_MOD;
        ae    = 64'(a);
        a1    = ae + 1;
        a1m   = a1 % PRIME_MOD;
        a1phi = a1 % PHI_MOD;
        d     = (pm + PRIME_MOD - 1) % PRIME_MOD;
        count_run = mul_mod(count_run, a1m);
        // A prime congruent to one has no inverse of p-1; the series sums to a+1.
        if (d == 0) begin
            sfac = a1m;
        end else begin
            sfac = mul_mod((pow_mod(pm, a1) + PRIME_MOD - 1) % PRIME_MOD,
                           pow_mod(d, PRIME_MOD - 2));
        end
        sum_run = mul_mod(sum_run, sfac);
        // The product update uses the count modulo phi from before this pair.
        term = pow_mod(pm, (ae * a1) / 2);
        product_run = mul_mod(pow_mod(product_run, a1), pow_mod(term, count_phi_run));
        count_phi_run = (count_phi_run * a1phi) % PHI_MOD;
        if (l) begin
            r.count   = count_run[29:0];
            r.sum     = sum_run[29:0];
            r.product = product_run[29:0];
            divisor_q.push_back(r);
            count_run = 1;
            sum_run = 1;
            product_run = 1;
            count_phi_run = 1;
        end
    endfunction

    task automatic report_mismatch(string field, bit [29:0] got, bit [29:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    task automatic add_pair(bit [29:0] p, bit [29:0] a, bit l);
        t_pair w;
        w.prime = p;
        w.expo = a;
        w.last = l;
        pair_q.push_back(w);
    endtask

    function automatic bit [29:0] rand_prime();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 30'($urandom_range(2, 97));
        if (sel < 70) return 30'(dcsp_pkg::MOD_P) + 30'($urandom_range(0, 3));
        if (sel < 75) return 30'($urandom_range(0, 1));
        return 30'($urandom);
    endfunction

    function automatic bit [29:0] rand_expo();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) return 30'($urandom_range(0, 40));
        if (sel < 90) return 30'($urandom_range(0, 1 << 20));
        return 30'($urandom);
    endfunction

    // Input driver: a new word goes out at the falling edge once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || in_taken)) begin
            if (pair_q.size() > 0 &&
                (($urandom_range(0, 99) >= 32) || (pairs_sent >= 700 && pairs_sent < 1000))) begin
                next_pair = pair_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.prime <= next_pair.prime;
                in_ch.prime_exponent <= next_pair.expo;
                in_ch.last <= next_pair.last;
                pairs_sent++;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, one long hold-off, and a stretch always ready.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (results_seen == 20 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 4000;
            out_ch.ready <= 1'b0;
        end else if (results_seen >= 200 && results_seen < 280) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= 32);
        end
    end

    // Monitor: predict on accepted pairs, compare accepted result words.
    always @(posedge i_clk) begin
        in_taken <= in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                fold_divisor_pair(in_ch.prime, in_ch.prime_exponent, in_ch.last);
                pairs_taken++;
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (divisor_q.size() == 0) begin
                    $display("UNEXPECTED result word at %0t", $realtime);
                    errors++;
                end else begin
                    if (out_ch.divisor_count != divisor_q[0].count)
                        report_mismatch("divisor_count", out_ch.divisor_count, divisor_q[0].count);
                    if (out_ch.divisor_sum != divisor_q[0].sum)
                        report_mismatch("divisor_sum", out_ch.divisor_sum, divisor_q[0].sum);
                    if (out_ch.divisor_product != divisor_q[0].product)
                        report_mismatch("divisor_product", out_ch.divisor_product,
                                        divisor_q[0].product);
                    void'(divisor_q.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("divisor_count_sum_product_mod_core test failed");
                $finish;
            end
        end
    end

    initial begin
        int len;
        count_run = 1;
        sum_run = 1;
        product_run = 1;
        count_phi_run = 1;
        errors = 0;
        pairs_sent = 0;
        pairs_taken = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        in_taken = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.prime = '0;
        in_ch.prime_exponent = '0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;

        // Directed pairs: exponent zero, lone last pair, primes congruent to one and zero,
        // primes at and above the modulus, and the widest exponents.
        add_pair(30'd2, 30'd0, 1'b1);
        add_pair(30'd2, 30'd3, 1'b1);
        add_pair(30'd2, 30'd2, 1'b0);
        add_pair(30'd3, 30'd1, 1'b0);
        add_pair(30'd5, 30'd4, 1'b1);
        add_pair(30'd1, 30'd5, 1'b1);
        add_pair(30'(dcsp_pkg::MOD_P) + 30'd1, 30'd7, 1'b1);
        add_pair(30'd0, 30'd0, 1'b1);
        add_pair(30'd0, 30'd6, 1'b1);
        add_pair(30'(dcsp_pkg::MOD_P), 30'd3, 1'b1);
        add_pair(30'(dcsp_pkg::MOD_P_M1), 30'd9, 1'b1);
        add_pair(30'h3FFF_FFFF, 30'h3FFF_FFFF, 1'b1);
        add_pair(30'd2, 30'h3FFF_FFFF, 1'b0);
        add_pair(30'd7, 30'h2AAA_AAAA, 1'b0);
        add_pair(30'd11, 30'h1555_5555, 1'b1);
        add_pair(30'd1, 30'd0, 1'b0);
        add_pair(30'(dcsp_pkg::MOD_P), 30'h3FFF_FFFF, 1'b1);

        // Random factorizations of one to six pairs, each closed by a last pair.
        while (pair_q.size() < ITEM_TARGET) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                add_pair(rand_prime(), rand_expo(), k == len - 1);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pair_q.size() == 0);
        @(posedge i_clk);
        while (in_ch.valid) @(posedge i_clk);
        while (divisor_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d factor pairs and %0d divisor results,", pairs_taken, results_seen);
        $display("with a long output hold-off that stalled the input.");
        if (errors == 0) begin
            $display("divisor_count_sum_product_mod_core test passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("divisor_count_sum_product_mod_core test failed");
        end
        $finish;
    end

endmodule
